@@ src/demand_paging_translator_top_assert.svh @@
// assertion macros used by the checker file
`ifndef DEMAND_PAGING_TRANSLATOR_TOP_ASSERT_SVH
`define DEMAND_PAGING_TRANSLATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpt check failed");

// next-cycle implication
`define DPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpt check failed");

`endif

@@ src/dpt_pkg.sv @@
package dpt_pkg;

    localparam int VADDR_W       = 20;
    localparam int DATA_W        = 32;
    localparam int PHYS_W        = 12;
    localparam int PAGE_W        = 10;
    localparam int VICTIM_W      = 2;
    localparam int FILL_W        = 2;
    localparam int PAGE_WORDS    = 1024;
    localparam int OFFSET_W      = $clog2(PAGE_WORDS);
    localparam int VIRTUAL_PAGES = 1024;

    typedef logic [PAGE_W-1:0] page_t;

    typedef enum logic
    {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // frame map changes from the request in the lookup stage
    typedef struct packed
    {
        logic map;
        logic mark_dirty;
    } map_update_t;

    // frame map answers for the request in the lookup stage
    typedef struct packed
    {
        logic  hit;
        logic  evict_valid;
        page_t evict_page;
        logic  evict_dirty;
    } lookup_t;

endpackage

@@ src/dpt_page_mem.sv @@
module dpt_page_mem
#(
    parameter int FRAME_W = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dpt_pkg::page_t     rd_page,
    input  logic               wr_en,
    input  dpt_pkg::page_t     wr_page,
    input  logic               wr_ref,
    input  logic [FRAME_W-1:0] wr_frame,
    output logic               q_ref,
    output logic [FRAME_W-1:0] q_frame,
    output logic               clearing
);
    import dpt_pkg::*;

    // entry: referenced bit above the last mapped frame
    logic [FRAME_W:0] mem [VIRTUAL_PAGES];
    logic [FRAME_W:0] rd_data_reg;
    logic [FRAME_W:0] byp_data_reg;
    logic             byp_sel_reg;
    logic             clearing_reg;
    logic             clearing_next;
    page_t            clr_page_reg;
    page_t            clr_page_next;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_page_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_page] <= {wr_ref, wr_frame};
        end
        rd_data_reg  <= mem[rd_page];
        // read and write of the same page at one edge: take the new entry
        byp_sel_reg  <= wr_en && (wr_page == rd_page);
        byp_data_reg <= {wr_ref, wr_frame};
    end

    always_comb
    begin
        clr_page_next = clr_page_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_page_next = clr_page_reg + PAGE_W'(1);
            if (clr_page_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_page_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_page_reg <= clr_page_next;
        end
    end

    assign q_ref    = byp_sel_reg ? byp_data_reg[FRAME_W] : rd_data_reg[FRAME_W];
    assign q_frame  = byp_sel_reg ? byp_data_reg[FRAME_W-1:0] : rd_data_reg[FRAME_W-1:0];
    assign clearing = clearing_reg;

endmodule

@@ src/dpt_frame_map.sv @@
module dpt_frame_map
#(
    parameter int FRAMES  = 4,
    parameter int FRAME_W = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpt_pkg::page_t       page,
    input  logic [FRAME_W-1:0]   entry_frame,
    input  logic [FRAME_W-1:0]   victim,
    input  dpt_pkg::map_update_t update,
    output dpt_pkg::lookup_t     lookup
);
    import dpt_pkg::*;

    localparam logic [FRAME_W:0] FRAME_COUNT = (FRAME_W + 1)'(FRAMES);

    logic  owner_valid_reg [FRAMES];
    page_t owner_page_reg  [FRAMES];
    logic  dirty_reg       [FRAMES];
    logic  entry_in_range;

    assign entry_in_range = {1'b0, entry_frame} < FRAME_COUNT;

    // a page is mapped only while its last frame still names it as owner
    always_comb
    begin
        lookup.hit = 1'b0;
        if (entry_in_range)
        begin
            lookup.hit = owner_valid_reg[entry_frame]
                         && (owner_page_reg[entry_frame] == page);
        end
        lookup.evict_valid = owner_valid_reg[victim];
        lookup.evict_page  = owner_page_reg[victim];
        lookup.evict_dirty = dirty_reg[victim];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FRAMES; f++)
            begin
                owner_valid_reg[f] <= 1'b0;
                dirty_reg[f]       <= 1'b0;
            end
        end
        else if (update.map)
        begin
            owner_valid_reg[victim] <= 1'b1;
            dirty_reg[victim]       <= 1'b0;
        end
        else if (update.mark_dirty)
        begin
            dirty_reg[entry_frame] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update.map)
        begin
            owner_page_reg[victim] <= page;
        end
    end

endmodule

@@ src/demand_paging_translator_top.sv @@
// channel   direction  handshake       payload
// request   in         start / busy    command, vaddr, write_data, victim_frame
// result    out        done (strobe)   hit, phys_addr, mem_write, mem_write_data,
//                                      evict_valid, evict_page, writeback_needed,
//                                      load_needed, fill_frame, load_page
//
// one request per cycle while busy is low; each result reaches done through the
// lookup and result registers; after reset busy stays high while the ram is cleared
// the page table ram has one write and one registered read each cycle; a write
// from the request in flight is forwarded to the request just read
// the receiver cannot stall, so busy only ever reflects the clearing pass
module demand_paging_translator_top
#(
    parameter int FRAMES = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [dpt_pkg::VADDR_W-1:0]   vaddr,
    input  logic [dpt_pkg::DATA_W-1:0]    write_data,
    input  logic [dpt_pkg::VICTIM_W-1:0]  victim_frame,
    output logic                          done,
    output logic                          hit,
    output logic [dpt_pkg::PHYS_W-1:0]    phys_addr,
    output logic                          mem_write,
    output logic [dpt_pkg::DATA_W-1:0]    mem_write_data,
    output logic                          evict_valid,
    output logic [dpt_pkg::PAGE_W-1:0]    evict_page,
    output logic                          writeback_needed,
    output logic                          load_needed,
    output logic [dpt_pkg::FILL_W-1:0]    fill_frame,
    output logic [dpt_pkg::PAGE_W-1:0]    load_page
);
    import dpt_pkg::*;

    localparam int FRAME_W     = $clog2(FRAMES);
    // victim codes at or above the frame count wrap round once
    localparam bit VICTIM_WRAP = (FRAMES < 4);

    // lookup stage: request registers
    logic                s1_valid_reg;
    cmd_t                s1_command_reg;
    page_t               s1_page_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic [VICTIM_W-1:0] s1_victim_reg;

    // result registers
    logic                done_reg;
    logic                hit_reg;
    logic [PHYS_W-1:0]   phys_addr_reg;
    logic                mem_write_reg;
    logic [DATA_W-1:0]   mem_write_data_reg;
    logic                evict_valid_reg;
    page_t               evict_page_reg;
    logic                writeback_needed_reg;
    logic                load_needed_reg;
    logic [FILL_W-1:0]   fill_frame_reg;
    page_t               load_page_reg;

    logic                hit_next;
    logic [PHYS_W-1:0]   phys_addr_next;
    logic                mem_write_next;
    logic [DATA_W-1:0]   mem_write_data_next;
    logic                evict_valid_next;
    page_t               evict_page_next;
    logic                writeback_needed_next;
    logic                load_needed_next;
    logic [FILL_W-1:0]   fill_frame_next;
    page_t               load_page_next;

    logic                accept;
    logic                clearing;
    logic                q_ref;
    logic [FRAME_W-1:0]  q_frame;
    logic [VICTIM_W-1:0] victim_red;
    logic [FRAME_W-1:0]  victim_idx;
    logic                is_write;
    logic                miss;
    map_update_t         update;
    lookup_t             lookup;

    assign busy   = clearing;
    assign accept = start && !clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg <= cmd_t'(command);
            s1_page_reg    <= vaddr[OFFSET_W +: PAGE_W];
            s1_offset_reg  <= vaddr[OFFSET_W-1:0];
            s1_data_reg    <= write_data;
            s1_victim_reg  <= victim_frame;
        end
    end

    // page table ram: last frame and referenced bit of every page
    dpt_page_mem
    #(
        .FRAME_W (FRAME_W)
    )
    u_page_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_page  (vaddr[OFFSET_W +: PAGE_W]),
        .wr_en    (update.map),
        .wr_page  (s1_page_reg),
        .wr_ref   (q_ref || is_write),
        .wr_frame (victim_idx),
        .q_ref    (q_ref),
        .q_frame  (q_frame),
        .clearing (clearing)
    );

    always_comb
    begin
        victim_red = s1_victim_reg;
        if (VICTIM_WRAP && (s1_victim_reg >= VICTIM_W'(FRAMES)))
        begin
            victim_red = s1_victim_reg - VICTIM_W'(FRAMES);
        end
    end

    assign victim_idx = FRAME_W'(victim_red);
    assign is_write   = (s1_command_reg == CMD_WRITE);
    assign miss       = s1_valid_reg && !lookup.hit;

    // a miss remaps the victim frame; a write hit dirties the page's frame
    assign update.map        = miss;
    assign update.mark_dirty = s1_valid_reg && lookup.hit && is_write;

    // owner, valid and dirty per frame
    dpt_frame_map
    #(
        .FRAMES  (FRAMES),
        .FRAME_W (FRAME_W)
    )
    u_frame_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .page        (s1_page_reg),
        .entry_frame (q_frame),
        .victim      (victim_idx),
        .update      (update),
        .lookup      (lookup)
    );

    // result fields, zero where they do not apply
    always_comb
    begin
        hit_next              = lookup.hit;
        phys_addr_next        = '0;
        mem_write_next        = 1'b0;
        mem_write_data_next   = '0;
        evict_valid_next      = 1'b0;
        evict_page_next       = '0;
        writeback_needed_next = 1'b0;
        load_needed_next      = 1'b0;
        fill_frame_next       = '0;
        load_page_next        = '0;
        if (lookup.hit)
        begin
            phys_addr_next = PHYS_W'({q_frame, s1_offset_reg});
            if (is_write)
            begin
                mem_write_next      = 1'b1;
                mem_write_data_next = s1_data_reg;
            end
        end
        else
        begin
            if (lookup.evict_valid)
            begin
                evict_valid_next      = 1'b1;
                evict_page_next       = lookup.evict_page;
                writeback_needed_next = lookup.evict_dirty;
            end
            // a write to a page never touched creates it without a load
            load_needed_next = !(is_write && !q_ref);
            fill_frame_next  = victim_red;
            load_page_next   = s1_page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            hit_reg              <= hit_next;
            phys_addr_reg        <= phys_addr_next;
            mem_write_reg        <= mem_write_next;
            mem_write_data_reg   <= mem_write_data_next;
            evict_valid_reg      <= evict_valid_next;
            evict_page_reg       <= evict_page_next;
            writeback_needed_reg <= writeback_needed_next;
            load_needed_reg      <= load_needed_next;
            fill_frame_reg       <= fill_frame_next;
            load_page_reg        <= load_page_next;
        end
    end

    assign done             = done_reg;
    assign hit              = hit_reg;
    assign phys_addr        = phys_addr_reg;
    assign mem_write        = mem_write_reg;
    assign mem_write_data   = mem_write_data_reg;
    assign evict_valid      = evict_valid_reg;
    assign evict_page       = evict_page_reg;
    assign writeback_needed = writeback_needed_reg;
    assign load_needed      = load_needed_reg;
    assign fill_frame       = fill_frame_reg;
    assign load_page        = load_page_reg;

endmodule

@@ src/dpt_checker.sv @@
`include "demand_paging_translator_top_assert.svh"

module dpt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          hit,
    input logic                          mem_write,
    input logic                          evict_valid,
    input logic                          writeback_needed,
    input logic                          load_needed
);

    // every request gives exactly one result on done
    `DPT_ASSERT_IMP(a_request_gives_result, start && !busy, ##2 done)
    `DPT_ASSERT_IMP(a_result_has_request, done, $past(start && !busy, 2))

    // a hit does no miss work
    `DPT_ASSERT_IMP(a_hit_no_miss_work, done && hit, !evict_valid && !load_needed && !writeback_needed)

    // memory is only written on a hit
    `DPT_ASSERT_IMP(a_write_needs_hit, done && mem_write, hit)

    // once the table is cleared busy never returns
    `DPT_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

bind demand_paging_translator_top dpt_checker u_dpt_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// testbench for the demand paging translator
// requests go in on start / busy, one result per request comes back on done
// a local copy of the page table and the frame owner map predicts every result
module testbench;

    import dpt_pkg::*;

    localparam int NUM_FRAMES = 4;

    // one translation result, laid out as the result ports
    typedef struct packed
    {
        logic                hit;
        logic [PHYS_W-1:0]   phys_addr;
        logic                mem_write;
        logic [DATA_W-1:0]   mem_write_data;
        logic                evict_valid;
        page_t               evict_page;
        logic                writeback_needed;
        logic                load_needed;
        logic [FILL_W-1:0]   fill_frame;
        page_t               load_page;
    } translation_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 command;
    logic [VADDR_W-1:0]   vaddr;
    logic [DATA_W-1:0]    write_data;
    logic [VICTIM_W-1:0]  victim_frame;
    logic                 done;
    logic                 hit;
    logic [PHYS_W-1:0]    phys_addr;
    logic                 mem_write;
    logic [DATA_W-1:0]    mem_write_data;
    logic                 evict_valid;
    page_t                evict_page;
    logic                 writeback_needed;
    logic                 load_needed;
    logic [FILL_W-1:0]    fill_frame;
    page_t                load_page;

    // local copy of the page table
    logic                 pt_valid [VIRTUAL_PAGES];
    logic                 pt_dirty [VIRTUAL_PAGES];
    logic                 pt_referenced [VIRTUAL_PAGES];
    logic [FILL_W-1:0]    pt_frame [VIRTUAL_PAGES];

    // reverse map: which page currently lives in each frame
    logic                 owner_valid [NUM_FRAMES];
    page_t                owner_page [NUM_FRAMES];

    translation_t         expected_translations [$];
    int                   mismatch_count = 0;
    bit                   idle_on = 1'b1;

    demand_paging_translator_top
    #(
        .FRAMES (NUM_FRAMES)
    )
    u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .vaddr            (vaddr),
        .write_data       (write_data),
        .victim_frame     (victim_frame),
        .done             (done),
        .hit              (hit),
        .phys_addr        (phys_addr),
        .mem_write        (mem_write),
        .mem_write_data   (mem_write_data),
        .evict_valid      (evict_valid),
        .evict_page       (evict_page),
        .writeback_needed (writeback_needed),
        .load_needed      (load_needed),
        .fill_frame       (fill_frame),
        .load_page        (load_page)
    );

    // 4 ns period, high then low
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // applies one access to the local tables and returns what the block should answer
    function automatic translation_t translate_access(cmd_t cmd, logic [VADDR_W-1:0] va,
                                                      logic [DATA_W-1:0] wd,
                                                      logic [VICTIM_W-1:0] vf);
        translation_t         res;
        page_t                pg;
        logic [OFFSET_W-1:0]  offset;
        logic [FILL_W-1:0]    victim;
        page_t                old_pg;

        res    = '0;
        pg     = page_t'((va / PAGE_WORDS) % VIRTUAL_PAGES);
        offset = va[OFFSET_W-1:0];
        victim = FILL_W'(int'(vf) % NUM_FRAMES);

        if (pt_valid[pg])
        begin
            // hit: translate, and a write marks the page dirty
            res.hit       = 1'b1;
            res.phys_addr = PHYS_W'(int'(pt_frame[pg]) * PAGE_WORDS + int'(offset));
            if (cmd == CMD_WRITE)
            begin
                res.mem_write      = 1'b1;
                res.mem_write_data = wd;
                pt_dirty[pg]       = 1'b1;
            end
        end
        else
        begin
            // miss: throw out whoever owns the victim frame first
            if (owner_valid[victim])
            begin
                old_pg                = owner_page[victim];
                res.evict_valid       = 1'b1;
                res.evict_page        = old_pg;
                res.writeback_needed  = pt_dirty[old_pg];
                pt_valid[old_pg]      = 1'b0;
                pt_dirty[old_pg]      = 1'b0;
            end
            // a write to a never-touched page creates it without a load
            if (cmd == CMD_WRITE && !pt_referenced[pg])
            begin
                res.load_needed   = 1'b0;
                pt_referenced[pg] = 1'b1;
            end
            else
            begin
                res.load_needed = 1'b1;
            end
            pt_valid[pg]        = 1'b1;
            pt_dirty[pg]        = 1'b0;
            pt_frame[pg]        = victim;
            owner_valid[victim] = 1'b1;
            owner_page[victim]  = pg;
            res.fill_frame      = victim;
            res.load_page       = pg;
        end
        return res;
    endfunction

    // drives one request from the falling edge and waits until it is taken
    task automatic send_request(input cmd_t cmd, input logic [VADDR_W-1:0] va,
                                input logic [DATA_W-1:0] wd, input logic [VICTIM_W-1:0] vf,
                                output logic was_hit);
        int            gap;
        translation_t  res;

        gap = idle_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        vaddr        <= va;
        write_data   <= wd;
        victim_frame <= vf;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = translate_access(cmd, va, wd, vf);
        expected_translations.push_back(res);
        was_hit = res.hit;
    endtask

    // one access, then retries until it hits, as a caller would after a miss
    task automatic access_with_retry(input cmd_t cmd, input logic [VADDR_W-1:0] va,
                                     input logic [DATA_W-1:0] wd);
        logic  was_hit;

        send_request(cmd, va, wd, VICTIM_W'($urandom()), was_hit);
        while (!was_hit)
            send_request(cmd, va, wd, VICTIM_W'($urandom()), was_hit);
    endtask

    task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker: every done pulse is matched against the oldest prediction
    always @(posedge clk)
    begin
        translation_t  want;

        if (rst_n && done === 1'b1)
        begin
            if (expected_translations.size() == 0)
            begin
                $display("%0t ns: result with no request outstanding", $time);
                mismatch_count++;
            end
            else
            begin
                want = expected_translations.pop_front();
                report_field("hit", DATA_W'(want.hit), DATA_W'(hit));
                report_field("phys_addr", DATA_W'(want.phys_addr), DATA_W'(phys_addr));
                report_field("mem_write", DATA_W'(want.mem_write), DATA_W'(mem_write));
                report_field("mem_write_data", want.mem_write_data, mem_write_data);
                report_field("evict_valid", DATA_W'(want.evict_valid), DATA_W'(evict_valid));
                report_field("evict_page", DATA_W'(want.evict_page), DATA_W'(evict_page));
                report_field("writeback_needed", DATA_W'(want.writeback_needed),
                             DATA_W'(writeback_needed));
                report_field("load_needed", DATA_W'(want.load_needed), DATA_W'(load_needed));
                report_field("fill_frame", DATA_W'(want.fill_frame), DATA_W'(fill_frame));
                report_field("load_page", DATA_W'(want.load_page), DATA_W'(load_page));
            end
        end
    end

    // first touches: read miss with an empty frame, write creating a page,
    // hits at both ends of the address range and of the data word
    task automatic test_first_touch();
        logic  h;

        send_request(CMD_READ,  20'h00000, 32'h0000_0000, 2'd0, h);
        send_request(CMD_READ,  20'h00000, 32'hFFFF_FFFF, 2'd1, h);
        send_request(CMD_WRITE, 20'hFFFFF, 32'hFFFF_FFFF, 2'd3, h);
        send_request(CMD_WRITE, 20'hFFFFF, 32'hFFFF_FFFF, 2'd0, h);
        send_request(CMD_READ,  20'h003FF, 32'h0000_0000, 2'd2, h);
    endtask

    // evictions: dirty and clean victims, write miss on a page seen before,
    // a page evicted while dirty and then brought back
    task automatic test_eviction();
        logic  h;

        send_request(CMD_READ,  {10'd5, 10'h155},    32'h0000_0000, 2'd3, h);
        send_request(CMD_WRITE, {10'd1023, 10'h000}, 32'h0000_0000, 2'd0, h);
        send_request(CMD_WRITE, {10'd1023, 10'h000}, 32'h0000_0000, 2'd1, h);
        send_request(CMD_WRITE, {10'd2, 10'h2AA},    32'hA5A5_A5A5, 2'd1, h);
        send_request(CMD_WRITE, {10'd2, 10'h2AA},    32'h5A5A_5A5A, 2'd2, h);
        send_request(CMD_READ,  {10'd2, 10'h001},    32'h0000_0000, 2'd1, h);
        send_request(CMD_READ,  {10'd700, 10'h3FE},  32'h0000_0000, 2'd1, h);
        send_request(CMD_WRITE, {10'd2, 10'h2AA},    32'h1234_5678, 2'd2, h);
        send_request(CMD_READ,  {10'd5, 10'h000},    32'h0000_0000, 2'd0, h);
        send_request(CMD_READ,  {10'd1023, 10'h3FF}, 32'h0000_0000, 2'd0, h);
        send_request(CMD_WRITE, {10'd700, 10'h000},  32'h1234_5678, 2'd0, h);
        send_request(CMD_READ,  {10'd512, 10'h200},  32'h0000_0000, 2'd3, h);
    endtask

    // bulk of the run: a small working set of pages so that frames are shared
    // and reused, most accesses retried after a miss, with idle stretches toggled
    task automatic test_working_set_traffic(input int num_accesses);
        page_t  pool [6];
        cmd_t   cmd;
        int     i;
        logic   h;

        foreach (pool[k])
            pool[k] = page_t'($urandom());
        for (i = 0; i < num_accesses; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            // now and then swap a page of the working set for a fresh one
            if ($urandom_range(0, 29) == 0)
                pool[$urandom_range(0, 5)] = page_t'($urandom());
            cmd = cmd_t'($urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0)
                send_request(cmd, {pool[$urandom_range(0, 5)], OFFSET_W'($urandom())},
                             $urandom(), VICTIM_W'($urandom()), h);
            else
                access_with_retry(cmd, {pool[$urandom_range(0, 5)], OFFSET_W'($urandom())},
                                  $urandom());
        end
    endtask

    // noise: any address, any victim, no retries
    task automatic test_scattered_requests(input int num_requests);
        logic  h;

        repeat (num_requests)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            send_request(cmd_t'($urandom_range(0, 1)), VADDR_W'($urandom()), $urandom(),
                         VICTIM_W'($urandom()), h);
        end
    endtask

    initial
    begin
        // clear the local tables to the reset state
        foreach (pt_valid[p])
        begin
            pt_valid[p]      = 1'b0;
            pt_dirty[p]      = 1'b0;
            pt_referenced[p] = 1'b0;
            pt_frame[p]      = '0;
        end
        foreach (owner_valid[f])
        begin
            owner_valid[f] = 1'b0;
            owner_page[f]  = '0;
        end

        rst_n        = 1'b0;
        start        = 1'b0;
        command      = 1'b0;
        vaddr        = '0;
        write_data   = '0;
        victim_frame = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // busy covers the table clearing pass, the send task waits it out
        test_first_touch();
        test_eviction();
        test_working_set_traffic(450);
        test_scattered_requests(300);
        idle_on = 1'b1;
        test_working_set_traffic(100);

        @(negedge clk);
        start <= 1'b0;

        // let the pipeline drain, then wait on for stray strobes
        while (expected_translations.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
